// ===== hdl/assert_macros.svh =====
// assertion macros shared by the sequencer modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check with no reset qualifier
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/idsq_pkg.sv =====
// shared types and constants for the i2c display transfer sequencer
// no dependencies
`timescale 1ns / 1ps

package idsq_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;

   localparam logic [7:0] CTRL_CMD   = 8'h80;
   localparam logic [7:0] CTRL_DATA  = 8'h40;
   localparam logic [7:0] ADDR_RESET = 8'h78;

   localparam logic [1:0] XT_STD    = 2'd0;
   localparam logic [1:0] XT_REPEAT = 2'd2;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_START = 2'd1,
      ACT_SEND  = 2'd2,
      ACT_STOP  = 2'd3
   } act_type;

   typedef struct packed {
      logic [1:0]  xfer_type;
      logic [15:0] cmd_count;
      logic [15:0] data_count;
      logic [15:0] buffer_addr;
   } desc_type;

   typedef struct packed {
      logic        op;
      desc_type    desc;
      logic        ack_missing;
      logic        collision;
   } req_type;

   typedef struct packed {
      logic        enq_full;
      logic        kick;
      act_type     bus_action;
      logic        byte_from_memory;
      logic [7:0]  byte_value;
      logic [15:0] byte_addr;
      logic        free_valid;
      logic [15:0] free_addr;
   } rsp_type;

endpackage

// ===== hdl/idsq_ring.sv =====
// descriptor ring storage: one write port, one registered read port
// forwards a write that lands on the address read in the same cycle; uses idsq_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"

module idsq_ring
   import idsq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   localparam int IW = $clog2(QUEUE_DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  desc_type      wr_data,
   input  logic [IW-1:0] rd_addr,
   output desc_type      rd_data
);

   desc_type ring_mem_ff [QUEUE_DEPTH];
   desc_type mem_q_ff;
   desc_type byp_ff;
   logic     fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem_ff[wr_addr] <= wr_data;
      end
      mem_q_ff <= ring_mem_ff[rd_addr];
   end

   // same-address write and read: hand the new entry over
   always_ff @(posedge clock) begin
      fwd_ff <= wr_en && (wr_addr == rd_addr);
      byp_ff <= wr_data;
   end

   assign rd_data = fwd_ff ? byp_ff : mem_q_ff;

   `ASSERT_CLK(a_ring_fwd, clock, wr_en && (wr_addr == rd_addr) |=> rd_data == $past(wr_data), "ring read missed a same-cycle write")

endmodule

// ===== hdl/idsq_ctrl.sv =====
// sequencer control: ring pointers, transfer state and result decode
// drives the ring memory ports; uses idsq_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"

module idsq_ctrl
   import idsq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   localparam int IW = $clog2(QUEUE_DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_fire,
   input  req_type       req,
   input  logic          csr_we,
   input  logic [7:0]    csr_wdata,
   output logic          wr_en,
   output logic [IW-1:0] wr_addr,
   output desc_type      wr_data,
   output logic [IW-1:0] rd_addr,
   input  desc_type      head_desc,
   output rsp_type       result
);

   localparam logic [IW-1:0] LAST = IW'(QUEUE_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SENDADDR, ST_COMMAND, ST_STARTDATA, ST_DATA, ST_STOP
   } seq_state_type;

   typedef enum logic [1:0] {
      RS_EMPTY, RS_ACTIVE, RS_FULL
   } ring_status_type;

   seq_state_type   seq_state_ff, seq_state_in, st;
   ring_status_type status_ff, status_in;
   logic            control_next_ff, control_next_in;
   logic [IW-1:0]   head_ff, head_in, tail_ff, tail_in, head_next, tail_next;
   logic [1:0]      cur_type_ff, cur_type_in;
   logic [15:0]     cmd_left_ff, cmd_left_in, data_left_ff, data_left_in;
   logic [15:0]     read_ptr_ff, read_ptr_in, cur_base_ff, cur_base_in;
   logic [15:0]     cmd_dec, data_dec;
   logic [7:0]      i2c_addr_ff;

   function automatic rsp_type stop_rsp(input logic [1:0] t, input logic [15:0] base);
      rsp_type r;
      r            = '0;
      r.bus_action = ACT_STOP;
      if (t == XT_STD) begin
         r.free_valid = 1'b1;
         r.free_addr  = base;
      end
      return r;
   endfunction

   assign head_next = (head_ff == LAST) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == LAST) ? '0 : tail_ff + 1'b1;
   assign cmd_dec   = cmd_left_ff - 16'd1;
   assign data_dec  = data_left_ff - 16'd1;

   assign wr_addr = tail_ff;
   assign wr_data = req.desc;
   // keep the read port one step ahead so the head entry is ready next cycle
   assign rd_addr = head_in;

   always_comb begin
      seq_state_in    = seq_state_ff;
      status_in       = status_ff;
      control_next_in = control_next_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      cur_type_in     = cur_type_ff;
      cmd_left_in     = cmd_left_ff;
      data_left_in    = data_left_ff;
      read_ptr_in     = read_ptr_ff;
      cur_base_in     = cur_base_ff;
      result          = '0;
      wr_en           = 1'b0;
      st              = req.collision ? ST_IDLE : seq_state_ff;
      if (req_fire && !req.op) begin
         if (status_ff == RS_FULL) begin
            result.enq_full = 1'b1;
            if (req.desc.xfer_type == XT_STD) begin
               result.free_valid = 1'b1;
               result.free_addr  = req.desc.buffer_addr;
            end
         end else begin
            wr_en     = 1'b1;
            tail_in   = tail_next;
            status_in = (tail_next == head_ff) ? RS_FULL : RS_ACTIVE;
            result.kick = (seq_state_ff == ST_IDLE);
         end
      end else if (req_fire) begin
         seq_state_in = st;
         case (st)
            ST_IDLE: begin
               if (status_ff != RS_EMPTY) begin
                  cur_type_in  = head_desc.xfer_type;
                  cmd_left_in  = head_desc.cmd_count;
                  data_left_in = head_desc.data_count;
                  cur_base_in  = head_desc.buffer_addr;
                  read_ptr_in  = head_desc.buffer_addr;
                  head_in      = head_next;
                  status_in    = (head_next == tail_ff) ? RS_EMPTY : RS_ACTIVE;
                  seq_state_in = ST_SENDADDR;
                  result.bus_action = ACT_START;
               end
            end
            ST_SENDADDR: begin
               result.bus_action = ACT_SEND;
               result.byte_value = i2c_addr_ff;
               control_next_in   = 1'b1;
               if (cmd_left_ff != '0) begin
                  seq_state_in = ST_COMMAND;
               end else if (data_left_ff != '0) begin
                  seq_state_in = ST_STARTDATA;
               end else begin
                  seq_state_in = ST_STOP;
               end
            end
            ST_COMMAND: begin
               if (req.ack_missing) begin
                  result       = stop_rsp(cur_type_ff, cur_base_ff);
                  seq_state_in = ST_IDLE;
               end else if (control_next_ff) begin
                  result.bus_action = ACT_SEND;
                  result.byte_value = CTRL_CMD;
                  control_next_in   = 1'b0;
               end else begin
                  control_next_in         = 1'b1;
                  result.bus_action       = ACT_SEND;
                  result.byte_from_memory = 1'b1;
                  result.byte_addr        = read_ptr_ff;
                  read_ptr_in             = read_ptr_ff + 16'd1;
                  cmd_left_in             = cmd_dec;
                  if (cmd_dec == '0) begin
                     seq_state_in = (data_left_ff == '0) ? ST_STOP : ST_STARTDATA;
                  end
               end
            end
            ST_STARTDATA: begin
               if (req.ack_missing) begin
                  result       = stop_rsp(cur_type_ff, cur_base_ff);
                  seq_state_in = ST_IDLE;
               end else begin
                  result.bus_action = ACT_SEND;
                  result.byte_value = CTRL_DATA;
                  seq_state_in      = ST_DATA;
               end
            end
            ST_DATA: begin
               if (req.ack_missing) begin
                  result       = stop_rsp(cur_type_ff, cur_base_ff);
                  seq_state_in = ST_IDLE;
               end else begin
                  result.bus_action       = ACT_SEND;
                  result.byte_from_memory = 1'b1;
                  result.byte_addr        = read_ptr_ff;
                  // repeat type resends the same byte
                  if (cur_type_ff != XT_REPEAT) begin
                     read_ptr_in = read_ptr_ff + 16'd1;
                  end
                  data_left_in = data_dec;
                  if (data_dec == '0) begin
                     seq_state_in = ST_STOP;
                  end
               end
            end
            ST_STOP: begin
               result       = stop_rsp(cur_type_ff, cur_base_ff);
               seq_state_in = ST_IDLE;
            end
            default: begin
               seq_state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff    <= ST_IDLE;
         status_ff       <= RS_EMPTY;
         control_next_ff <= 1'b1;
         head_ff         <= '0;
         tail_ff         <= '0;
         cur_type_ff     <= '0;
         cmd_left_ff     <= '0;
         data_left_ff    <= '0;
         read_ptr_ff     <= '0;
         cur_base_ff     <= '0;
         i2c_addr_ff     <= ADDR_RESET;
      end else begin
         seq_state_ff    <= seq_state_in;
         status_ff       <= status_in;
         control_next_ff <= control_next_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         cur_type_ff     <= cur_type_in;
         cmd_left_ff     <= cmd_left_in;
         data_left_ff    <= data_left_in;
         read_ptr_ff     <= read_ptr_in;
         cur_base_ff     <= cur_base_in;
         if (csr_we) begin
            i2c_addr_ff <= csr_wdata;
         end
      end
   end

   `ASSERT_CLK_RST(a_full_ptrs, clock, reset, status_ff == RS_FULL |-> tail_ff == head_ff, "ring full but pointers differ")
   `ASSERT_CLK_RST(a_empty_ptrs, clock, reset, status_ff == RS_EMPTY |-> tail_ff == head_ff, "ring empty but pointers differ")
   `ASSERT_CLK_RST(a_no_start_empty, clock, reset, status_ff == RS_EMPTY |-> result.bus_action != ACT_START, "start issued from an empty ring")

endmodule

// ===== hdl/i2c_display_transfer_sequencer.sv =====
// top level of the i2c display transfer sequencer: ports, handshake, result register
// instantiates idsq_ring and idsq_ctrl; uses idsq_pkg
//
//   channel | ports | moves
//   request | req_* | enqueue of a descriptor, or a bus-ready event
//   result  | rsp_* | one result per request
//   config  | csr_* | write of the i2c address byte
//
// one request per cycle while req_ready is high; its result appears in the result register the next cycle
// the head descriptor is prefetched from the ring memory, so a start does not wait on a memory read
// req_ready falls only during reset or while a result is held and rsp_ready is low
// reset is synchronous; the ring contents stay undefined until written, no clearing pass
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2c_display_transfer_sequencer
   import idsq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [1:0]  req_xfer_type,
   input  logic [15:0] req_cmd_count,
   input  logic [15:0] req_data_count,
   input  logic [15:0] req_buffer_addr,
   input  logic        req_ack_missing,
   input  logic        req_collision,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_enq_full,
   output logic        rsp_kick,
   output logic [1:0]  rsp_bus_action,
   output logic        rsp_byte_from_memory,
   output logic [7:0]  rsp_byte_value,
   output logic [15:0] rsp_byte_addr,
   output logic        rsp_free_valid,
   output logic [15:0] rsp_free_addr,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata
);

   localparam int IW = $clog2(QUEUE_DEPTH);

   req_type       req;
   rsp_type       result;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;
   logic          req_fire;
   logic          wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   desc_type      wr_data, head_desc;

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = !reset;

   assign req.op               = req_op;
   assign req.desc.xfer_type   = req_xfer_type;
   assign req.desc.cmd_count   = req_cmd_count;
   assign req.desc.data_count  = req_data_count;
   assign req.desc.buffer_addr = req_buffer_addr;
   assign req.ack_missing      = req_ack_missing;
   assign req.collision        = req_collision;

   idsq_ring #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (head_desc)
   );

   idsq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req       (req),
      .csr_we    (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .head_desc (head_desc),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_enq_full         = rsp_ff.enq_full;
   assign rsp_kick             = rsp_ff.kick;
   assign rsp_bus_action       = rsp_ff.bus_action;
   assign rsp_byte_from_memory = rsp_ff.byte_from_memory;
   assign rsp_byte_value       = rsp_ff.byte_value;
   assign rsp_byte_addr        = rsp_ff.byte_addr;
   assign rsp_free_valid       = rsp_ff.free_valid;
   assign rsp_free_addr        = rsp_ff.free_addr;

   `ASSERT_CLK_RST(a_req_gives_rsp, clock, reset, req_fire |=> rsp_valid, "accepted request left no result")

endmodule
